// ===== rtl/rre_pkg.sv =====
// Shared types, constants and the clamp function of the RTT/RTO estimator.
`default_nettype none
package rre_pkg;

	localparam int RTO_W = 24;
	localparam int CNT_W = 8;
	localparam int CFG_W = 24;
	localparam int CFG_AW = 2;

	localparam logic [RTO_W-1:0] INIT_DEV    = 24'd750;
	localparam logic [RTO_W-1:0] RST_MIN_RTO = 24'd2000;
	localparam logic [RTO_W-1:0] RST_MAX_RTO = 24'd60000;
	localparam logic [CNT_W-1:0] RST_MAX_RTX = 8'd3;
	localparam logic [RTO_W-1:0] RST_RTO     = 24'd3000;
	localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;

	typedef enum logic [1:0] {
		OP_INIT       = 2'd0,
		OP_NEW_PACKET = 2'd1,
		OP_MEASURE    = 2'd2,
		OP_TIMEOUT    = 2'd3
	} op_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MIN_RTO  = 2'd0,
		CFG_MAX_RTO  = 2'd1,
		CFG_MAX_RETX = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [RTO_W-1:0] min_rto;
		logic [RTO_W-1:0] max_rto;
		logic [CNT_W-1:0] max_retx;
	} cfg_t;

	typedef struct packed {
		logic [RTO_W-1:0] srtt;
		logic [RTO_W-1:0] dev;
		logic [RTO_W-1:0] rto;
		logic [CNT_W-1:0] retry;
	} est_t;

	// With inverted limits the lower bound wins for values below it, the upper one otherwise.
	function automatic logic [RTO_W-1:0] clamp_rto(input logic [RTO_W+2:0] v, input cfg_t c);
		logic [RTO_W-1:0] r;
		if (v < {3'b000, c.min_rto}) begin
			r = c.min_rto;
		end else if (v > {3'b000, c.max_rto}) begin
			r = c.max_rto;
		end else begin
			r = v[RTO_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rre_cfg_regs.sv =====
// Configuration register file: RTO limits and retransmission limit.
`default_nettype none
module rre_cfg_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [rre_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire  [rre_pkg::CFG_W-1:0]   cfg_wdata,
	output rre_pkg::cfg_t               cfg
);

	rre_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rto  <= rre_pkg::RST_MIN_RTO;
			cfg_q.max_rto  <= rre_pkg::RST_MAX_RTO;
			cfg_q.max_retx <= rre_pkg::RST_MAX_RTX;
		end else if (cfg_we) begin
			unique case (rre_pkg::cfg_idx_t'(cfg_addr))
				rre_pkg::CFG_MIN_RTO:  cfg_q.min_rto  <= cfg_wdata[rre_pkg::RTO_W-1:0];
				rre_pkg::CFG_MAX_RTO:  cfg_q.max_rto  <= cfg_wdata[rre_pkg::RTO_W-1:0];
				rre_pkg::CFG_MAX_RETX: cfg_q.max_retx <= cfg_wdata[rre_pkg::CNT_W-1:0];
				default: ;  // unused index: drop the write
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/rre_update.sv =====
// Next estimator state and give-up flag for one event.
`default_nettype none
module rre_update (
	input  rre_pkg::op_t                op,
	input  wire  [rre_pkg::RTO_W-1:0]   sample,
	input  rre_pkg::est_t               est,
	input  rre_pkg::cfg_t               cfg,
	output rre_pkg::est_t               est_next,
	output logic                        give_up
);

	logic signed [rre_pkg::RTO_W:0]   delta;
	logic signed [rre_pkg::RTO_W:0]   q8;
	logic        [rre_pkg::RTO_W:0]   neg_delta;
	logic        [rre_pkg::RTO_W-1:0] mag;
	logic signed [rre_pkg::RTO_W+1:0] err;
	logic signed [rre_pkg::RTO_W+1:0] q4;
	logic        [rre_pkg::RTO_W-1:0] srtt_m;
	logic        [rre_pkg::RTO_W-1:0] dev_m;
	logic        [rre_pkg::RTO_W+2:0] sum_m;
	logic        [rre_pkg::RTO_W+2:0] sum_init;
	logic        [rre_pkg::RTO_W+2:0] dbl;
	logic        [rre_pkg::CNT_W-1:0] retry_inc;

	always_comb begin
		delta     = $signed({1'b0, sample}) - $signed({1'b0, est.srtt});
		// divide by eight, rounding toward zero
		q8        = (delta + (delta[rre_pkg::RTO_W] ? 25'sd7 : 25'sd0)) >>> 3;
		srtt_m    = est.srtt + q8[rre_pkg::RTO_W-1:0];
		neg_delta = 25'd0 - delta;
		mag       = delta[rre_pkg::RTO_W] ? neg_delta[rre_pkg::RTO_W-1:0]
		                                   : delta[rre_pkg::RTO_W-1:0];
		err       = $signed({2'b00, mag}) - $signed({2'b00, est.dev});
		q4        = (err + (err[rre_pkg::RTO_W+1] ? 26'sd3 : 26'sd0)) >>> 2;
		dev_m     = est.dev + q4[rre_pkg::RTO_W-1:0];
		sum_m     = {3'b000, srtt_m} + {1'b0, dev_m, 2'b00};
		sum_init  = {1'b0, rre_pkg::INIT_DEV, 2'b00};
		dbl       = {2'b00, est.rto, 1'b0};
		retry_inc = (est.retry == rre_pkg::CNT_MAX) ? est.retry : est.retry + 8'd1;

		est_next = est;
		give_up  = 1'b0;
		unique case (op)
			rre_pkg::OP_INIT: begin
				est_next.srtt = '0;
				est_next.dev  = rre_pkg::INIT_DEV;
				est_next.rto  = rre_pkg::clamp_rto(sum_init, cfg);
			end
			rre_pkg::OP_NEW_PACKET: begin
				est_next.retry = '0;
			end
			rre_pkg::OP_MEASURE: begin
				est_next.srtt = srtt_m;
				est_next.dev  = dev_m;
				est_next.rto  = rre_pkg::clamp_rto(sum_m, cfg);
			end
			rre_pkg::OP_TIMEOUT: begin
				est_next.rto   = rre_pkg::clamp_rto(dbl, cfg);
				est_next.retry = retry_inc;
				give_up        = retry_inc > cfg.max_retx;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/rtt_rto_estimator.sv =====
// A request passes through the input register and then the output register to m_tdata.
// Throughput: one request per cycle while m_tready does not stall the output; the state
// updates as the input register hands its request to the output register.
// Reset: arst_n clears both pipeline valids, loads the register defaults and sets
// smoothed RTT 0, deviation 750, RTO 3000 and retransmit count 0.
`default_nettype none
module rtt_rto_estimator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [23:0] sample
	input  wire  [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [23:0] timeout_value, [24] give_up,
	                               // [32:25] retransmit_count, [39:33] zero
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_addr,
	input  wire  [23:0] cfg_wdata
);

	rre_pkg::cfg_t cfg;
	rre_pkg::est_t est_q;
	rre_pkg::est_t est_next;
	logic          give_up;

	logic                      valid_s1;
	rre_pkg::op_t              op_s1;
	logic [rre_pkg::RTO_W-1:0] sample_s1;

	logic                      out_valid_q;
	logic [rre_pkg::RTO_W-1:0] out_rto_q;
	logic                      out_give_up_q;
	logic [rre_pkg::CNT_W-1:0] out_cnt_q;

	logic out_free;
	logic fire_s1;
	logic s_fire;

	rre_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rre_update u_upd (
		.op       (op_s1),
		.sample   (sample_s1),
		.est      (est_q),
		.cfg      (cfg),
		.est_next (est_next),
		.give_up  (give_up)
	);

	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1     <= rre_pkg::op_t'(s_tuser);
			sample_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q.srtt  <= '0;
			est_q.dev   <= rre_pkg::INIT_DEV;
			est_q.rto   <= rre_pkg::RST_RTO;
			est_q.retry <= '0;
		end else if (fire_s1) begin
			est_q <= est_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the downstream side takes it
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_rto_q     <= est_next.rto;
			out_give_up_q <= give_up;
			out_cnt_q     <= est_next.retry;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_give_up_q, out_rto_q};

`ifndef NO_ASSERTIONS
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(est_q))
		else $error("estimator state changed without a request");

	a_new_packet_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && op_s1 == rre_pkg::OP_NEW_PACKET |=> est_q.retry == '0)
		else $error("new packet did not clear the retransmit count");

	a_give_up_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_give_up_q |-> out_cnt_q != '0)
		else $error("give-up flagged with zero retransmit count");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled while pipeline has room");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_rtt_rto_estimator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the RTT/RTO estimator: a directed table, then random limit phases.
module tb_rtt_rto_estimator;

	localparam int RTO_W  = rre_pkg::RTO_W;
	localparam int CNT_W  = rre_pkg::CNT_W;
	localparam int CFG_W  = rre_pkg::CFG_W;
	localparam int CFG_AW = rre_pkg::CFG_AW;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 60;
	localparam int MIXED_ITEMS    = 80;
	localparam int STORM_ITEMS    = 320;
	localparam int NUM_PHASES     = 8;
	localparam int STEADY_PHASE   = 3;
	localparam int HOLD_PHASE     = 4;
	localparam int PAUSE_PHASE    = 5;
	localparam int STORM_PHASE    = 2;
	localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

	// Same layout as m_tdata, lowest field last.
	typedef struct packed {
		logic [6:0]       pad;
		logic [CNT_W-1:0] cnt;
		logic             give_up;
		logic [RTO_W-1:0] rto;
	} rto_report_t;

	typedef struct packed {
		rre_pkg::op_t     op;
		logic [RTO_W-1:0] smp;
		logic             fixed;
		logic [RTO_W-1:0] rto;
		logic             give_up;
		logic [CNT_W-1:0] cnt;
	} directed_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;   // [23:0] sample
	logic [1:0]        s_tuser;   // [1:0] operation
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [39:0]       m_tdata;   // [23:0] timeout_value, [24] give_up,
	                              // [32:25] retransmit_count, [39:33] zero
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_W-1:0]  cfg_wdata;

	// Estimator state and limits as the block should hold them
	logic [RTO_W-1:0] est_srtt;
	logic [RTO_W-1:0] est_dev;
	logic [RTO_W-1:0] est_rto;
	logic [CNT_W-1:0] est_retry;
	logic [RTO_W-1:0] lim_min;
	logic [RTO_W-1:0] lim_max;
	logic [CNT_W-1:0] lim_retx;

	rto_report_t rto_reports_due[$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  steady = 1'b0;
	int  op_seen[4] = '{0, 0, 0, 0};
	int  give_ups_seen = 0;
	int  peak_retry = 0;
	int  settings_used = 0;

	directed_row_t directed_rows [0:19] = '{
		'{rre_pkg::OP_NEW_PACKET, 24'h000000, 1'b1, 24'd3000,  1'b0, 8'd0},
		'{rre_pkg::OP_INIT,       24'hFFFFFF, 1'b1, 24'd3000,  1'b0, 8'd0},
		'{rre_pkg::OP_TIMEOUT,    24'h000000, 1'b1, 24'd6000,  1'b0, 8'd1},
		'{rre_pkg::OP_TIMEOUT,    24'hAAAAAA, 1'b1, 24'd12000, 1'b0, 8'd2},
		'{rre_pkg::OP_TIMEOUT,    24'h555555, 1'b1, 24'd24000, 1'b0, 8'd3},
		'{rre_pkg::OP_TIMEOUT,    24'h000000, 1'b1, 24'd48000, 1'b1, 8'd4},
		'{rre_pkg::OP_TIMEOUT,    24'hFFFFFF, 1'b1, 24'd60000, 1'b1, 8'd5},
		'{rre_pkg::OP_NEW_PACKET, 24'h123456, 1'b1, 24'd60000, 1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'h000000, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'hFFFFFF, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'hFFFFFF, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'h000000, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'h000001, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'hAAAAAA, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'h555555, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_TIMEOUT,    24'h000000, 1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_INIT,       24'h000000, 1'b1, 24'd3000,  1'b0, 8'd1},
		'{rre_pkg::OP_MEASURE,    24'd3000,   1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_MEASURE,    24'd2990,   1'b0, 24'd0,     1'b0, 8'd0},
		'{rre_pkg::OP_TIMEOUT,    24'h000000, 1'b0, 24'd0,     1'b0, 8'd0}
	};

	rtt_rto_estimator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Lower limit checked first: with inverted limits it wins for values below it
	function automatic logic [RTO_W-1:0] bound_rto(input longint v);
		longint lo;
		longint hi;
		lo = lim_min;
		hi = lim_max;
		if (v < lo) begin
			return lim_min;
		end else if (v > hi) begin
			return lim_max;
		end
		return v[RTO_W-1:0];
	endfunction

	function automatic rto_report_t update_estimator(input rre_pkg::op_t op,
			input logic [RTO_W-1:0] smp);
		rto_report_t res;
		longint srtt;
		longint dev;
		longint dlt;
		longint mag;
		logic   gu;
		srtt = est_srtt;
		dev  = est_dev;
		gu   = 1'b0;
		case (op)
			rre_pkg::OP_INIT: begin
				est_srtt = '0;
				est_dev  = rre_pkg::INIT_DEV;
				est_rto  = bound_rto(4 * longint'(rre_pkg::INIT_DEV));
			end
			rre_pkg::OP_NEW_PACKET: begin
				est_retry = '0;
			end
			rre_pkg::OP_MEASURE: begin
				dlt  = longint'(smp) - srtt;
				mag  = (dlt < 0) ? -dlt : dlt;
				// signed division truncates toward zero
				srtt = srtt + dlt / 8;
				dev  = dev + (mag - dev) / 4;
				est_srtt = srtt[RTO_W-1:0];
				est_dev  = dev[RTO_W-1:0];
				srtt = est_srtt;
				dev  = est_dev;
				est_rto = bound_rto(srtt + 4 * dev);
			end
			default: begin
				est_rto = bound_rto(2 * longint'(est_rto));
				if (est_retry != rre_pkg::CNT_MAX) begin
					est_retry = est_retry + 1'b1;
				end
				gu = (est_retry > lim_retx);
			end
		endcase
		res.pad     = '0;
		res.cnt     = est_retry;
		res.give_up = gu;
		res.rto     = est_rto;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		if (mismatches < 100) begin
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
		end
		mismatches++;
	endtask

	// Enter just after a falling edge; leave at the falling edge after acceptance.
	task automatic offer_request(input rre_pkg::op_t op, input logic [RTO_W-1:0] smp,
			input logic fixed, input rto_report_t fixed_val);
		rto_report_t predicted;
		while (!steady && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			s_tdata  <= RTO_W'($urandom);
			s_tuser  <= 2'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= op;
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = update_estimator(op, smp);
		rto_reports_due.push_back(fixed ? fixed_val : predicted);
		op_seen[op]++;
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (rto_reports_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_register(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			rre_pkg::CFG_MIN_RTO:  lim_min  = val;
			rre_pkg::CFG_MAX_RTO:  lim_max  = val;
			rre_pkg::CFG_MAX_RETX: lim_retx = val[CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [RTO_W-1:0] lo, input logic [RTO_W-1:0] hi,
			input logic [CNT_W-1:0] retx, input bit spare);
		set_register(rre_pkg::CFG_MIN_RTO, lo);
		set_register(rre_pkg::CFG_MAX_RTO, hi);
		// upper bits of the retransmit limit are junk and must be dropped
		set_register(rre_pkg::CFG_MAX_RETX, {16'($urandom), retx});
		if (spare) begin
			set_register(CFG_SPARE, CFG_W'($urandom));
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 16);
		end
	end

	always @(posedge clk) begin
		rto_report_t got;
		rto_report_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else if (m_tvalid === 1'b1 && m_tready) begin
				got = m_tdata;
				if (rto_reports_due.size() == 0) begin
					report_mismatch("result with nothing expected", got, '0);
				end else begin
					want = rto_reports_due.pop_front();
					if (got.rto !== want.rto)
						report_mismatch("timeout_value", got.rto, want.rto);
					if (got.give_up !== want.give_up)
						report_mismatch("give_up", got.give_up, want.give_up);
					if (got.cnt !== want.cnt)
						report_mismatch("retransmit_count", got.cnt, want.cnt);
					if (got.pad !== want.pad)
						report_mismatch("padding bits", got.pad, want.pad);
					if (got.give_up === 1'b1)
						give_ups_seen++;
					if (int'(got.cnt) > peak_retry)
						peak_retry = got.cnt;
				end
			end
		end
	end

	initial begin
		int               p;
		int               r;
		int               n;
		bit               storm;
		rre_pkg::op_t     op;
		logic [RTO_W-1:0] smp;
		logic [RTO_W-1:0] lo;
		logic [RTO_W-1:0] hi;
		logic [CNT_W-1:0] retx;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = rre_pkg::OP_INIT;
		cfg_we    = 1'b0;
		cfg_addr  = rre_pkg::CFG_MIN_RTO;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		est_srtt  = '0;
		est_dev   = rre_pkg::INIT_DEV;
		est_rto   = rre_pkg::RST_RTO;
		est_retry = '0;
		lim_min   = rre_pkg::RST_MIN_RTO;
		lim_max   = rre_pkg::RST_MAX_RTO;
		lim_retx  = rre_pkg::RST_MAX_RTX;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part runs on the reset limits
		foreach (directed_rows[i]) begin
			offer_request(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].fixed,
				{7'd0, directed_rows[i].cnt, directed_rows[i].give_up, directed_rows[i].rto});
		end
		drain_results();

		for (p = 0; p < NUM_PHASES; p++) begin
			storm  = (p == STORM_PHASE);
			n      = storm ? STORM_ITEMS : MIXED_ITEMS;
			steady = (p == STEADY_PHASE);
			case (p)
				0: begin lo = '0;   hi = '1;        retx = '0;   end
				1: begin lo = '1;   hi = '0;        retx = '1;   end
				2: begin lo = 1000; hi = 20000;     retx = '1;   end
				// count is near saturation after the storm, so a limit of 254 gives up
				3: begin lo = 500;  hi = 100000;    retx = 254;  end
				4: begin
					lo   = $urandom_range(0, 20000);
					hi   = $urandom_range(lo, 24'hFFFFFF);
					retx = $urandom_range(0, 255);
				end
				5: begin
					lo   = $urandom_range(50000, 200000);
					hi   = $urandom_range(1000, 40000);
					retx = $urandom_range(0, 10);
				end
				6: begin
					lo   = $urandom_range(1000, 100000);
					hi   = lo;
					retx = $urandom_range(0, 8);
				end
				default: begin
					lo   = rre_pkg::RST_MIN_RTO;
					hi   = rre_pkg::RST_MAX_RTO;
					retx = rre_pkg::RST_MAX_RTX;
				end
			endcase
			set_limits(lo, hi, retx, p == HOLD_PHASE);
			for (int k = 0; k < n; k++) begin
				if (p == HOLD_PHASE && k == 40)
					hold_req = 1'b1;
				if (p == PAUSE_PHASE && k == 40)
					drain_results();
				r = $urandom_range(0, 99);
				if (storm)
					op = (r < 10) ? rre_pkg::OP_MEASURE : rre_pkg::OP_TIMEOUT;
				else if (r < 8)
					op = rre_pkg::OP_INIT;
				else if (r < 20)
					op = rre_pkg::OP_NEW_PACKET;
				else if (r < 65)
					op = rre_pkg::OP_MEASURE;
				else
					op = rre_pkg::OP_TIMEOUT;
				case ($urandom_range(0, 9))
					0: smp = '0;
					1: smp = '1;
					2, 3: smp = RTO_W'($urandom);
					// land close to the smoothed RTT to exercise truncation of small deltas
					4, 5: smp = est_srtt + RTO_W'($urandom_range(0, 64)) - RTO_W'(32);
					default: smp = RTO_W'($urandom_range(0, 200000));
				endcase
				offer_request(op, smp, 1'b0, '0);
			end
			drain_results();
		end
		steady = 1'b0;
		repeat (10) @(posedge clk);

		$display("Sent %0d init, %0d new packet, %0d measurement and %0d timeout requests",
			op_seen[rre_pkg::OP_INIT], op_seen[rre_pkg::OP_NEW_PACKET],
			op_seen[rre_pkg::OP_MEASURE], op_seen[rre_pkg::OP_TIMEOUT]);
		$display("Across %0d limit settings: %0d give-ups, retransmit count peaked at %0d",
			settings_used, give_ups_seen, peak_retry);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rre_pkg.sv
rtl/rre_cfg_regs.sv
rtl/rre_update.sv
rtl/rtt_rto_estimator.sv
dv/tb_rtt_rto_estimator.sv
